// ===== hw/rtl/mamm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average monitor package
// Shared widths, reset constants and the controller/datapath command types.
// ----------------------------------------------------------------------------
package mamm_pkg;

	// Field widths of the sample and result transactions.
	localparam int unsigned SAMPLE_W  = 32;
	localparam int unsigned TIME_W    = 48;
	localparam int unsigned AVG_W     = 40;
	localparam int unsigned CNT_OUT_W = 6;
	localparam int unsigned FRAC_W    = 8;

	// Default window length and reset value of the clear period register.
	localparam int unsigned WINDOW_DEF = 60;
	localparam logic [SAMPLE_W-1:0] CLEAR_PERIOD_RST = 32'd60000000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;     // latch the sample, add it to the sum, read the oldest entry
		logic update;     // retire the oldest entry, write the ring, update min/max
		logic div_start;  // load the divider with sum*256 and the count
		logic out_load;   // copy results into the output register
	} mamm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;   // last quotient bit is being written
		logic div_busy;   // divider is iterating
	} mamm_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mamm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average monitor channels
// Valid/ready channels for sample transactions and result transactions.
// ----------------------------------------------------------------------------
interface mamm_in_if;
	import mamm_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_value;
	logic [TIME_W-1:0]   now_us;

	modport source (output valid, output sample_value, output now_us, input ready);
	modport sink   (input valid, input sample_value, input now_us, output ready);
endinterface

interface mamm_out_if;
	import mamm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [AVG_W-1:0]     average_q8;
	logic [SAMPLE_W-1:0]  max_value;
	logic [SAMPLE_W-1:0]  min_value;
	logic [CNT_OUT_W-1:0] sample_count;

	modport source (output valid, output average_q8, output max_value, output min_value,
		output sample_count, input ready);
	modport sink   (input valid, input average_q8, input max_value, input min_value,
		input sample_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mamm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mamm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mamm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average monitor divider
// Restoring unsigned divider that resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mamm_div #(
	parameter int unsigned DW  = 46,
	parameter int unsigned DVW = 6
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [DW-1:0]  dividend,
	input  wire logic [DVW-1:0] divisor,
	output logic      [DW-1:0]  quotient,
	output logic                busy,
	output logic                done
);

	localparam int unsigned STEPW = $clog2(DW + 1);

	logic [DVW-1:0]   rem_q;
	logic [DVW-1:0]   dvs_q;
	logic [DW-1:0]    quo_q;
	logic [STEPW-1:0] step_q;
	logic             busy_q;
	logic [DVW:0]     trial;
	logic [DVW:0]     diff;
	logic             ge;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEPW'(DW);
		end else if (busy_q) begin
			step_q <= step_q - STEPW'(1);
			if (step_q == STEPW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift register; the dividend is consumed in place.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;
	assign done     = busy_q && (step_q == STEPW'(1));

endmodule
`default_nettype wire

// ===== hw/rtl/mamm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average monitor controller
// Sequences one sample through update, division and result hand-off.
// ----------------------------------------------------------------------------
module mamm_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output mamm_pkg::mamm_cmd_t       cmd,
	input  wire mamm_pkg::mamm_stat_t stat
);
	import mamm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_START,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	// Commands decoded from the current state.
	always_comb begin
		cmd           = '0;
		cmd.accept    = (state_q == ST_IDLE) && in_valid;
		cmd.update    = (state_q == ST_UPDATE);
		cmd.div_start = (state_q == ST_START);
		cmd.out_load  = (state_q == ST_DONE) && out_free;
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A drained result clears valid unless a new one is loaded this cycle.
			if (out_valid_q && out_ready && !cmd.out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (stat.div_done || !stat.div_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/mamm_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average monitor datapath
// Sample ring, running sum, min/max tracking, divider and output register.
// ----------------------------------------------------------------------------
module mamm_dpath #(
	parameter int unsigned WINDOW = mamm_pkg::WINDOW_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [mamm_pkg::SAMPLE_W-1:0]       cfg_wdata,
	input  wire logic [mamm_pkg::SAMPLE_W-1:0]       sample_value,
	input  wire logic [mamm_pkg::TIME_W-1:0]         now_us,
	input  wire mamm_pkg::mamm_cmd_t                 cmd,
	output mamm_pkg::mamm_stat_t                     stat,
	output logic      [mamm_pkg::AVG_W-1:0]          average_q8,
	output logic      [mamm_pkg::SAMPLE_W-1:0]       max_value,
	output logic      [mamm_pkg::SAMPLE_W-1:0]       min_value,
	output logic      [mamm_pkg::CNT_OUT_W-1:0]      sample_count
);
	import mamm_pkg::*;

	localparam int unsigned PW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CNTW = $clog2(WINDOW + 1);
	localparam int unsigned SUMW = SAMPLE_W + CNTW;
	localparam int unsigned DW   = SUMW + FRAC_W;
	localparam int unsigned CXW  = CNTW + CNT_OUT_W;

	logic [SAMPLE_W-1:0] period_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [TIME_W-1:0]   now_q;
	logic                first_q;
	logic                full_q;
	logic [PW-1:0]       pos_q;
	logic [CNTW-1:0]     count_q;
	logic [SUMW-1:0]     sum_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [TIME_W-1:0]   last_q;
	logic [SAMPLE_W-1:0] oldest;
	logic [TIME_W:0]     deadline;
	logic                restart;
	logic [DW-1:0]       quotient;
	logic                div_busy;
	logic                div_done;
	logic [CXW-1:0]      cnt_ext;

	// Clear period register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= CLEAR_PERIOD_RST;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	// Sample ring; the oldest entry is read on accept and overwritten in the next cycle, on update.
	mamm_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (WINDOW),
		.AW    (PW)
	) u_ring (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (pos_q),
		.wdata (sample_q),
		.re    (cmd.accept),
		.raddr (pos_q),
		.rdata (oldest)
	);

	// Latched transaction fields and the flags that depend on the fill level.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample_value;
			now_q    <= now_us;
			first_q  <= (count_q == '0);
			full_q   <= (count_q == CNTW'(WINDOW));
		end
	end

	// Restart test at full width so the deadline cannot wrap.
	assign deadline = {1'b0, last_q} + (TIME_W + 1)'(period_q);
	assign restart  = first_q || (deadline < {1'b0, now_q});

	// Running sum, fill count, ring position and min/max state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			pos_q   <= '0;
			max_q   <= '0;
			min_q   <= '0;
			last_q  <= '0;
		end else begin
			if (cmd.accept) begin
				sum_q <= sum_q + SUMW'(sample_value);
			end
			if (cmd.update) begin
				if (full_q) begin
					sum_q <= sum_q - SUMW'(oldest);
				end else begin
					count_q <= count_q + CNTW'(1);
				end
				pos_q <= (pos_q == PW'(WINDOW - 1)) ? '0 : pos_q + PW'(1);
				if (restart) begin
					last_q <= now_q;
					max_q  <= sample_q;
					min_q  <= sample_q;
				end else begin
					if (sample_q > max_q) begin
						max_q <= sample_q;
					end
					if (sample_q < min_q) begin
						min_q <= sample_q;
					end
				end
			end
		end
	end

	// Average: sum scaled by 256 divided by the fill count.
	mamm_div #(
		.DW  (DW),
		.DVW (CNTW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({sum_q, FRAC_W'(0)}),
		.divisor  (count_q),
		.quotient (quotient),
		.busy     (div_busy),
		.done     (div_done)
	);

	always_comb begin
		stat          = '0;
		stat.div_done = div_done;
		stat.div_busy = div_busy;
	end

	// The reported count keeps its low bits only.
	assign cnt_ext = CXW'(count_q);

	// Output register holds the result until the consumer takes it.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			average_q8   <= quotient[AVG_W-1:0];
			max_value    <= max_q;
			min_value    <= min_q;
			sample_count <= cnt_ext[CNT_OUT_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/moving_average_min_max_monitor_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average monitor with restartable min/max
// Top level: controller, datapath and the channel and configuration ports.
// ----------------------------------------------------------------------------
// Each accepted sample is added to a ring of the last WINDOW samples and
// produces one result: the floor of the mean times 256, the maximum and
// minimum since the last restart, and the number of samples averaged. The
// minimum and maximum restart on the first sample after reset and whenever
// more than clear_period_us microseconds have passed since the last restart.
// A sample passes from accept through the update, divider start, division and
// result hand-off states before the next one can be accepted, and it stays in
// hand-off while the previous result waits unread. The restoring divider
// produces one quotient bit per cycle. A finished result waits in the output
// register while the next sample is taken. clear_period_us is written through
// cfg_we/cfg_wdata; the user must do so only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module moving_average_min_max_monitor_core #(
	parameter int unsigned WINDOW = mamm_pkg::WINDOW_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mamm_pkg::SAMPLE_W-1:0] cfg_wdata,
	mamm_in_if.sink                            sample_in,
	mamm_out_if.source                         result_out
);
	import mamm_pkg::*;

	mamm_cmd_t  cmd;
	mamm_stat_t stat;

	// Transaction sequencing.
	mamm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_in.valid),
		.in_ready  (sample_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Storage and arithmetic.
	mamm_dpath #(
		.WINDOW (WINDOW)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.sample_value (sample_in.sample_value),
		.now_us       (sample_in.now_us),
		.cmd          (cmd),
		.stat         (stat),
		.average_q8   (result_out.average_q8),
		.max_value    (result_out.max_value),
		.min_value    (result_out.min_value),
		.sample_count (result_out.sample_count)
	);

endmodule
`default_nettype wire
